/* src/qpp_pkg.sv */
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared constants, register codes and lane types of the queue pick block.
// ----------------------------------------------------------------------------
package qpp_pkg;

   // number of occupancy ports and their width
   localparam int NUM_PORTS = 8;
   localparam int OCC_W     = 16;
   localparam int IDX_W     = 3;
   localparam int CNT_W     = 4;

   // parameter defaults
   localparam int QUEUES_DEF   = 8;
   localparam int OCC_BITS_DEF = 16;

   // register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MODE       = 1'b0;
   localparam logic REG_NUM_QUEUES = 1'b1;

   // pick rule codes; codes above the largest rule pick queue 0
   localparam logic [2:0] MODE_SMALLEST = 3'd0;
   localparam logic [2:0] MODE_CYCLIC   = 3'd1;
   localparam logic [2:0] MODE_RANDOM   = 3'd2;
   localparam logic [2:0] MODE_FIRST    = 3'd3;
   localparam logic [2:0] MODE_LARGEST  = 3'd4;

   // reset values
   localparam logic [2:0]       MODE_RESET = MODE_SMALLEST;
   localparam logic [CNT_W-1:0] NUMQ_RESET = 4'd8;
   localparam logic [15:0]      LFSR_SEED  = 16'hACE1;
   localparam logic [15:0]      LFSR_TAPS  = 16'hB400;

   // what one lane hands to the merge tree
   typedef struct packed {
      logic             active;
      logic [OCC_W-1:0] key;
   } lane_type;

endpackage

/* src/qpp_lane.sv */
// ----------------------------------------------------------------------------
// qpp_lane
// One queue lane: masks the occupancy, folds the largest rule into a
// smallest search and marks whether the queue is in use.
// ----------------------------------------------------------------------------
module qpp_lane
   import qpp_pkg::*;
#(
   parameter int LANE_IDX = 0,
   parameter int OCC_BITS = OCC_BITS_DEF
) (
   input  logic [OCC_W-1:0] occupancy,
   input  logic [CNT_W-1:0] active_count,
   input  logic             invert,
   output lane_type         lane
);

   localparam int CMP_BITS = (OCC_BITS < OCC_W) ? OCC_BITS : OCC_W;
   localparam logic [OCC_W-1:0] KEY_MASK = OCC_W'((33'd1 << CMP_BITS) - 33'd1);
   localparam logic [CNT_W-1:0] LANE_POS = CNT_W'(LANE_IDX);

   logic [OCC_W-1:0] masked;

   // largest search runs as smallest over complemented keys
   always_comb begin
      masked      = occupancy & KEY_MASK;
      lane.key    = invert ? (~masked & KEY_MASK) : masked;
      lane.active = (LANE_POS < active_count);
   end

endmodule

/* src/qpp_merge.sv */
// ----------------------------------------------------------------------------
// qpp_merge
// Merge tree over all lanes: finds the active lane with the smallest key,
// ties going to the lower index.
// ----------------------------------------------------------------------------
module qpp_merge
   import qpp_pkg::*;
(
   input  lane_type         lanes [NUM_PORTS],
   output logic [IDX_W-1:0] best_idx
);

   typedef struct packed {
      logic             active;
      logic [OCC_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } node_type;

   node_type lvl0 [8];
   node_type lvl1 [4];
   node_type lvl2 [2];
   node_type root;

   // right node wins only when strictly better
   function automatic node_type pick_node(input node_type a, input node_type b);
      node_type r;
      if (b.active && (!a.active || (b.key < a.key))) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         lvl0[i].active = lanes[i].active;
         lvl0[i].key    = lanes[i].key;
         lvl0[i].idx    = IDX_W'(i);
      end
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = pick_node(lvl0[2*i], lvl0[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = pick_node(lvl1[2*i], lvl1[2*i+1]);
      end
      root     = pick_node(lvl2[0], lvl2[1]);
      best_idx = root.idx;
   end

endmodule

/* src/queue_pick_policy_unit.sv */
// ----------------------------------------------------------------------------
// queue_pick_policy_unit
// Picks one queue per request under the configured rule.
// The pick is registered in the output register, or in the skid entry if the
// output is held. Throughput: one request per clock while req_stall is low;
// eight lanes, a three-level merge tree and the pointer and LFSR update are
// combinational. A two-entry output buffer takes requests while a result waits.
// Reset: mode smallest, 8 queues, cyclic pointer 0, LFSR 0xACE1, buffer empty.
// ----------------------------------------------------------------------------
module queue_pick_policy_unit
   import qpp_pkg::*;
#(
   parameter int QUEUES   = QUEUES_DEF,
   parameter int OCC_BITS = OCC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OCC_W-1:0]      req_occupancy_0,
   input  logic [OCC_W-1:0]      req_occupancy_1,
   input  logic [OCC_W-1:0]      req_occupancy_2,
   input  logic [OCC_W-1:0]      req_occupancy_3,
   input  logic [OCC_W-1:0]      req_occupancy_4,
   input  logic [OCC_W-1:0]      req_occupancy_5,
   input  logic [OCC_W-1:0]      req_occupancy_6,
   input  logic [OCC_W-1:0]      req_occupancy_7,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_W-1:0]      rsp_queue_index,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [CNT_W-1:0] QUEUE_MAX = CNT_W'(QUEUES);

   logic [2:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] numq_ff, numq_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [15:0]      lfsr_ff, lfsr_in;
   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [IDX_W-1:0] skid_idx_ff, skid_idx_in;

   logic             csr_write;
   logic             accept;
   logic             take;
   logic             out_free;
   logic [CNT_W-1:0] active_count;
   logic [OCC_W-1:0] occ [NUM_PORTS];
   lane_type         lanes [NUM_PORTS];
   logic [IDX_W-1:0] tree_idx;
   logic [IDX_W-1:0] cyc_pick;
   logic [CNT_W-1:0] cyc_next;
   logic [15:0]      lfsr_step;
   logic [19:0]      scaled;
   logic [IDX_W-1:0] pick;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      numq_in = numq_ff;
      if (csr_write) begin
         if (paddr[2] == REG_MODE) begin
            mode_in = pwdata[2:0];
         end else begin
            numq_in = pwdata[CNT_W-1:0];
         end
      end
      if (paddr[2] == REG_MODE) begin
         prdata = {{(CSR_DATA_W-3){1'b0}}, mode_ff};
      end else begin
         prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, numq_ff};
      end
   end

   // clamp the queue count to 1..QUEUES
   always_comb begin
      if (numq_ff == '0) begin
         active_count = CNT_W'(1);
      end else if (numq_ff > QUEUE_MAX) begin
         active_count = QUEUE_MAX;
      end else begin
         active_count = numq_ff;
      end
   end

   // lanes and merge tree
   assign occ[0] = req_occupancy_0;
   assign occ[1] = req_occupancy_1;
   assign occ[2] = req_occupancy_2;
   assign occ[3] = req_occupancy_3;
   assign occ[4] = req_occupancy_4;
   assign occ[5] = req_occupancy_5;
   assign occ[6] = req_occupancy_6;
   assign occ[7] = req_occupancy_7;

   for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
      qpp_lane #(
         .LANE_IDX (g),
         .OCC_BITS (OCC_BITS)
      ) u_lane (
         .occupancy    (occ[g]),
         .active_count (active_count),
         .invert       (mode_ff == MODE_LARGEST),
         .lane         (lanes[g])
      );
   end

   qpp_merge u_merge (
      .lanes    (lanes),
      .best_idx (tree_idx)
   );

   // cyclic pointer, stale pointer falls back to queue 0
   always_comb begin
      cyc_pick = ({1'b0, ptr_ff} < active_count) ? ptr_ff : '0;
      cyc_next = CNT_W'(cyc_pick) + CNT_W'(1);
      if (cyc_next == active_count) begin
         cyc_next = '0;
      end
   end

   // galois lfsr step and scaling into 0..n-1
   always_comb begin
      lfsr_step = {1'b0, lfsr_ff[15:1]};
      if (lfsr_ff[0]) begin
         lfsr_step = lfsr_step ^ LFSR_TAPS;
      end
      scaled = {4'b0, lfsr_step} * {16'b0, active_count};
   end

   // rule select
   always_comb begin
      case (mode_ff)
         MODE_SMALLEST: pick = tree_idx;
         MODE_LARGEST:  pick = tree_idx;
         MODE_CYCLIC:   pick = cyc_pick;
         MODE_RANDOM:   pick = scaled[16 +: IDX_W];
         MODE_FIRST:    pick = '0;
         default:       pick = '0;
      endcase
   end

   // rule state advances only in its own mode
   always_comb begin
      ptr_in  = ptr_ff;
      lfsr_in = lfsr_ff;
      if (accept && (mode_ff == MODE_CYCLIC)) begin
         ptr_in = cyc_next[IDX_W-1:0];
      end
      if (accept && (mode_ff == MODE_RANDOM)) begin
         lfsr_in = lfsr_step;
      end
   end

   // output register with skid entry
   assign req_stall       = skid_valid_ff;
   assign accept          = req_valid && !req_stall;
   assign take            = out_valid_ff && !rsp_stall;
   assign out_free        = !out_valid_ff || take;
   assign rsp_valid       = out_valid_ff;
   assign rsp_queue_index = out_idx_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_idx_in    = out_idx_ff;
      skid_valid_in = skid_valid_ff;
      skid_idx_in   = skid_idx_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_idx_in   = skid_idx_ff;
         end else begin
            out_valid_in = accept;
            out_idx_in   = pick;
         end
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_idx_in   = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         numq_ff       <= NUMQ_RESET;
         ptr_ff        <= '0;
         lfsr_ff       <= LFSR_SEED;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         numq_ff       <= numq_in;
         ptr_ff        <= ptr_in;
         lfsr_ff       <= lfsr_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff  <= out_idx_in;
      skid_idx_ff <= skid_idx_in;
   end

   // skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // the lfsr never locks up at zero
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("lfsr reached zero");

   // lfsr holds unless a random-mode request is taken
   a_lfsr_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && (mode_ff == MODE_RANDOM)) |=> $stable(lfsr_ff))
      else $error("lfsr moved outside random mode");

   // a fresh pick in the output register lies inside the queue count
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (accept && out_free && !skid_valid_ff) |=> ({1'b0, out_idx_ff} < $past(active_count)))
      else $error("picked queue outside active range");

endmodule
